// ----- hw/rtl/rsplt_pkg.sv -----
// ----------------------------------------------------------------------------
// rsplt_pkg
// Shared constants and types for the raw split tiler: register indexes,
// register reset values, field widths and default frame limits.
// ----------------------------------------------------------------------------
package rsplt_pkg;

    localparam int DEF_MAX_WIDTH  = 8192;
    localparam int DEF_MAX_HEIGHT = 8192;

    // Field widths of the stream items
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 26;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 48;

    // Configuration register widths
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_WIDTH_W = 14;
    localparam int CFG_OVL_W   = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_OVERLAP      = 2'd2,
        CFG_REMOSAIC     = 2'd3
    } t_cfg_index;

    localparam logic [CFG_WIDTH_W-1:0] RST_IMAGE_WIDTH  = 14'd4096;
    localparam logic [CFG_WIDTH_W-1:0] RST_IMAGE_HEIGHT = 14'd3072;
    localparam logic [CFG_OVL_W-1:0]   RST_OVERLAP      = 13'd64;
    localparam logic                   RST_REMOSAIC     = 1'b1;

endpackage

// ----- hw/rtl/rsplt_coord.sv -----
// ----------------------------------------------------------------------------
// rsplt_coord
// Raster column/row counters with optional remosaic of the coordinates:
// positions 1 and 2 of each group of four are swapped on both axes, unless
// the swapped position would fall outside the frame.
// ----------------------------------------------------------------------------
module rsplt_coord #(
    parameter int MAX_WIDTH  = rsplt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsplt_pkg::DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_advance,
    input  logic [WW-1:0] i_width,
    input  logic [HW-1:0] i_height,
    input  logic          i_remosaic,
    output logic [CW-1:0] o_x,
    output logic [RW-1:0] o_y
);

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic [1:0]    x_lo;
    logic [1:0]    y_lo;
    logic [WW-1:0] x_up;
    logic [HW-1:0] y_up;

    assign col_inc = WW'(r_col) + WW'(1);
    assign row_inc = HW'(r_row) + HW'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_clear) begin
            n_col = '0;
            n_row = '0;
        end else if (i_advance) begin
            if (col_inc >= i_width) begin
                n_col = '0;
                n_row = (row_inc >= i_height) ? '0 : RW'(row_inc);
            end else begin
                n_col = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Swap positions 1 and 2 of each group of four; moving down never leaves the frame
    assign x_lo = 2'(r_col);
    assign y_lo = 2'(r_row);
    assign x_up = col_inc;
    assign y_up = row_inc;

    always_comb begin
        o_x = r_col;
        o_y = r_row;
        if (i_remosaic) begin
            if (x_lo == 2'd1 && x_up < i_width) begin
                o_x = CW'(x_up);
            end else if (x_lo == 2'd2) begin
                o_x = r_col - CW'(1);
            end
            if (y_lo == 2'd1 && y_up < i_height) begin
                o_y = RW'(y_up);
            end else if (y_lo == 2'd2) begin
                o_y = r_row - RW'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/raw_split_tiler_with_remosaic_unit.sv -----
// ----------------------------------------------------------------------------
// raw_split_tiler_with_remosaic_unit
// Splits a raster raw pixel stream into a left and a right tile with an
// overlap band, repacking each 12-bit pixel into left-aligned bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per item in raster order (upper byte, lower
//   byte). m_axis carries one write per item: tile in tuser, tile-local
//   element index and the two output bytes in tdata, and tlast set on the
//   final write caused by a pixel. Overlap pixels give two writes, left
//   tile first.
//   The cfg channel writes image width, image height, overlap and remosaic
//   enable; it is always ready. Writing width or height restarts the frame.
//   A pixel passes the coordinate, multiply and output registers before its
//   first write on m_axis. Throughput: one pixel per cycle outside the
//   overlap band if m_axis is ready; inside it, two writes per pixel.
//   The pipeline holds three items (coordinate stage, multiply stage, output
//   stage); the stages advance independently, and when m_axis stalls they
//   fill and then s_axis_tready drops.
//   Reset restores the register defaults (4096 x 3072, overlap 64,
//   remosaic on), clears the counters and empties the pipeline.
// ----------------------------------------------------------------------------
module raw_split_tiler_with_remosaic_unit #(
    parameter int MAX_WIDTH  = rsplt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsplt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // cfg
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rsplt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rsplt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] upper_byte, [15:8] lower_byte
    input  logic [rsplt_pkg::S_DATA_W-1:0]        s_axis_tdata,
    // tile writes
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [25:0] element_index, [33:26] high_out, [41:34] low_out, [47:42] zero
    output logic [rsplt_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // [0] tile_select
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HALF_W = WW - 1;
    localparam int IDX_W  = rsplt_pkg::IDX_W;
    localparam int BYTE_W = rsplt_pkg::BYTE_W;
    localparam int PAD_W  = rsplt_pkg::M_DATA_W - IDX_W - 2 * BYTE_W;

    // Configuration registers
    logic [rsplt_pkg::CFG_WIDTH_W-1:0] r_cfg_width;
    logic [rsplt_pkg::CFG_WIDTH_W-1:0] r_cfg_height;
    logic [rsplt_pkg::CFG_OVL_W-1:0]   r_cfg_overlap;
    logic                              r_cfg_remosaic;
    logic                              cfg_fire;
    logic                              geom_clear;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width    <= rsplt_pkg::RST_IMAGE_WIDTH;
            r_cfg_height   <= rsplt_pkg::RST_IMAGE_HEIGHT;
            r_cfg_overlap  <= rsplt_pkg::RST_OVERLAP;
            r_cfg_remosaic <= rsplt_pkg::RST_REMOSAIC;
        end else if (cfg_fire) begin
            case (rsplt_pkg::t_cfg_index'(i_cfg_index))
                rsplt_pkg::CFG_IMAGE_WIDTH:  r_cfg_width    <= i_cfg_data;
                rsplt_pkg::CFG_IMAGE_HEIGHT: r_cfg_height   <= i_cfg_data;
                rsplt_pkg::CFG_OVERLAP:
                    r_cfg_overlap <= i_cfg_data[rsplt_pkg::CFG_OVL_W-1:0];
                rsplt_pkg::CFG_REMOSAIC:     r_cfg_remosaic <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign geom_clear = cfg_fire &&
        (rsplt_pkg::t_cfg_index'(i_cfg_index) == rsplt_pkg::CFG_IMAGE_WIDTH ||
         rsplt_pkg::t_cfg_index'(i_cfg_index) == rsplt_pkg::CFG_IMAGE_HEIGHT);

    // Effective geometry: clamp width and height, saturate overlap at half width
    logic [WW-1:0]     eff_w;
    logic [HW-1:0]     eff_h;
    logic [HALF_W-1:0] half_w;
    logic [HALF_W-1:0] ovl;
    logic [WW-1:0]     tile_w;
    logic [HALF_W-1:0] left_only;

    always_comb begin
        if (32'(r_cfg_width) < 32'(4)) begin
            eff_w = WW'(4);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_cfg_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_height);
        end
    end

    assign half_w    = eff_w[WW-1:1];
    assign ovl       = (32'(r_cfg_overlap) > 32'(half_w)) ? half_w : HALF_W'(r_cfg_overlap);
    assign tile_w    = WW'(half_w) + WW'(ovl);
    assign left_only = half_w - ovl;

    // Pipeline handshake
    logic r1_valid, r2_valid, r3_valid;
    logic s_fire, m_fire, done3;
    logic en1, en2, en3, mv12, mv23;

    assign s_fire = s_axis_tvalid & s_axis_tready;
    assign m_fire = m_axis_tvalid & m_axis_tready;

    logic r3_both, r3_phase, r3_ronly;

    assign done3 = m_fire & (~r3_both | r3_phase);
    assign en3   = ~r3_valid | done3;
    assign mv23  = r2_valid & en3;
    assign en2   = ~r2_valid | mv23;
    assign mv12  = r1_valid & en2;
    assign en1   = ~r1_valid | mv12;

    assign s_axis_tready = en1;

    // Stage 1: coordinates and byte repack
    logic [CW-1:0]     cur_x;
    logic [RW-1:0]     cur_y;
    logic [CW-1:0]     r1_x;
    logic [RW-1:0]     r1_y;
    logic [BYTE_W-1:0] r1_hi, r1_lo;

    rsplt_coord #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_coord (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (geom_clear),
        .i_advance  (s_fire),
        .i_width    (eff_w),
        .i_height   (eff_h),
        .i_remosaic (r_cfg_remosaic),
        .o_x        (cur_x),
        .o_y        (cur_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s_fire) begin
            r1_valid <= 1'b1;
        end else if (mv12) begin
            r1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r1_x  <= cur_x;
            r1_y  <= cur_y;
            r1_hi <= {s_axis_tdata[3:0], s_axis_tdata[15:12]};
            r1_lo <= {s_axis_tdata[11:8], 4'h0};
        end
    end

    // Stage 2: row base product and tile classification
    logic [RW+WW-1:0]  row_prod;
    logic [IDX_W-1:0]  r2_base;
    logic [CW-1:0]     r2_x;
    logic [WW-1:0]     r2_xr;
    logic              r2_lonly, r2_ronly;
    logic [BYTE_W-1:0] r2_hi, r2_lo;

    assign row_prod = r1_y * tile_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv12) begin
            r2_base  <= IDX_W'(row_prod);
            r2_x     <= r1_x;
            r2_xr    <= WW'(r1_x) - WW'(left_only);
            r2_lonly <= WW'(r1_x) < WW'(left_only);
            r2_ronly <= WW'(r1_x) >= tile_w;
            r2_hi    <= r1_hi;
            r2_lo    <= r1_lo;
        end
    end

    // Stage 3: output register, one or two writes per pixel
    logic [IDX_W-1:0]  r3_idx_l, r3_idx_r;
    logic [BYTE_W-1:0] r3_hi, r3_lo;
    logic              tile_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r3_phase <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
            r3_phase <= 1'b0;
        end else if (m_fire) begin
            // first of two writes taken, advance to the right tile
            r3_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv23) begin
            r3_idx_l <= r2_base + IDX_W'(r2_x);
            r3_idx_r <= r2_base + IDX_W'(r2_xr);
            r3_both  <= ~r2_lonly & ~r2_ronly;
            r3_ronly <= r2_ronly;
            r3_hi    <= r2_hi;
            r3_lo    <= r2_lo;
        end
    end

    assign tile_sel      = r3_both ? r3_phase : r3_ronly;
    assign m_axis_tvalid = r3_valid;
    assign m_axis_tuser  = tile_sel;
    assign m_axis_tlast  = ~r3_both | r3_phase;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r3_lo, r3_hi, tile_sel ? r3_idx_r : r3_idx_l};

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for raw_split_tiler_with_remosaic_unit. Pixels are
// streamed in phases, each under its own frame geometry, overlap and remosaic
// setting. A local tile-split model predicts every tile write, and each write
// on m_axis is compared field by field. Sender gaps and receiver stalls vary
// from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W      = rsplt_pkg::IDX_W;
    localparam int CFG_DATA_W = rsplt_pkg::CFG_DATA_W;
    localparam int S_DATA_W   = rsplt_pkg::S_DATA_W;
    localparam int M_DATA_W   = rsplt_pkg::M_DATA_W;

    typedef struct packed {
        logic             tile;
        logic [IDX_W-1:0] index;
        logic [7:0]       high_byte;
        logic [7:0]       low_byte;
        logic             last;
    } t_tile_write;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    rsplt_pkg::t_cfg_index i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    raw_split_tiler_with_remosaic_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Pixels waiting to be sent: [7:0] upper byte, [15:8] lower byte
    logic [S_DATA_W-1:0] pixel_q[$];
    t_tile_write         tile_writes_q[$];

    // Local copy of the registers and the raster counters
    logic [rsplt_pkg::CFG_WIDTH_W-1:0] geo_width;
    logic [rsplt_pkg::CFG_WIDTH_W-1:0] geo_height;
    logic [rsplt_pkg::CFG_OVL_W-1:0]   geo_overlap;
    logic                              geo_remosaic;
    logic [12:0]                       col_count;
    logic [12:0]                       row_count;

    int  sender_idle_pct;
    int  sink_stall_pct;
    logic pixel_taken;
    int  mismatch_count;
    int  pixels_sent;
    int  writes_checked;
    int  split_pixels;
    int  phase_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned clamp_width(int unsigned w);
        if (w < 4) return 4;
        if (w > rsplt_pkg::DEF_MAX_WIDTH) return rsplt_pkg::DEF_MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned clamp_height(int unsigned h);
        if (h < 1) return 1;
        if (h > rsplt_pkg::DEF_MAX_HEIGHT) return rsplt_pkg::DEF_MAX_HEIGHT;
        return h;
    endfunction

    // Swap positions 1 and 2 of each group of four; keep c if the target leaves the frame
    function automatic int unsigned remosaic_pos(int unsigned c, int unsigned extent);
        int unsigned r;
        r = c;
        if (c[1:0] == 2'd1) r = c + 1;
        else if (c[1:0] == 2'd2) r = c - 1;
        if (r >= extent) r = c;
        return r;
    endfunction

    function automatic void predict_tile_writes(logic [7:0] upper, logic [7:0] lower);
        int unsigned w, h, half, ov, tile_w, left_only, x, y;
        logic [IDX_W-1:0] base;
        t_tile_write wr;
        w         = clamp_width(geo_width);
        h         = clamp_height(geo_height);
        half      = w >> 1;
        ov        = (geo_overlap > half) ? half : geo_overlap;
        tile_w    = half + ov;
        left_only = half - ov;
        x         = col_count;
        y         = row_count;
        if (geo_remosaic) begin
            x = remosaic_pos(x, w);
            y = remosaic_pos(y, h);
        end
        base         = IDX_W'(longint'(y) * tile_w);
        wr.high_byte = {upper[3:0], lower[7:4]};
        wr.low_byte  = {lower[3:0], 4'h0};
        if (x < left_only || x >= tile_w) begin
            wr.tile  = (x >= tile_w);
            wr.index = wr.tile ? base + IDX_W'(x - left_only) : base + IDX_W'(x);
            wr.last  = 1'b1;
            tile_writes_q.push_back(wr);
        end else begin
            wr.tile  = 1'b0;
            wr.index = base + IDX_W'(x);
            wr.last  = 1'b0;
            tile_writes_q.push_back(wr);
            wr.tile  = 1'b1;
            wr.index = base + IDX_W'(x - left_only);
            wr.last  = 1'b1;
            tile_writes_q.push_back(wr);
            split_pixels++;
        end
        if (col_count + 1 >= w) begin
            col_count = '0;
            row_count = (row_count + 1 >= h) ? '0 : row_count + 1'b1;
        end else begin
            col_count = col_count + 1'b1;
        end
    endfunction

    // Pixel driver: hold the item until taken, then maybe idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || pixel_taken)) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: predict on pixel accept, check on write accept
    always @(posedge i_clk) begin
        t_tile_write exp_wr;
        if (!i_rst_n) begin
            pixel_taken <= 1'b0;
        end else begin
            pixel_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_tile_writes(s_axis_tdata[7:0], s_axis_tdata[15:8]);
                pixels_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                writes_checked++;
                if (tile_writes_q.size() == 0) begin
                    $error("unexpected tile write: index %0d", m_axis_tdata[25:0]);
                    mismatch_count++;
                end else begin
                    exp_wr = tile_writes_q.pop_front();
                    if (m_axis_tuser !== exp_wr.tile) begin
                        $error("tile_select: expected %0d, got %0d", exp_wr.tile,
                               m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[25:0] !== exp_wr.index) begin
                        $error("element_index: expected %0d, got %0d", exp_wr.index,
                               m_axis_tdata[25:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[33:26] !== exp_wr.high_byte) begin
                        $error("high_out: expected 0x%02h, got 0x%02h", exp_wr.high_byte,
                               m_axis_tdata[33:26]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[41:34] !== exp_wr.low_byte) begin
                        $error("low_out: expected 0x%02h, got 0x%02h", exp_wr.low_byte,
                               m_axis_tdata[41:34]);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== exp_wr.last) begin
                        $error("last_of_run: expected %0d, got %0d", exp_wr.last,
                               m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic write_reg(rsplt_pkg::t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rsplt_pkg::CFG_IMAGE_WIDTH: begin
                geo_width = data;
                col_count = '0;
                row_count = '0;
            end
            rsplt_pkg::CFG_IMAGE_HEIGHT: begin
                geo_height = data;
                col_count  = '0;
                row_count  = '0;
            end
            rsplt_pkg::CFG_OVERLAP:  geo_overlap  = data[rsplt_pkg::CFG_OVL_W-1:0];
            rsplt_pkg::CFG_REMOSAIC: geo_remosaic = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned ov,
                                logic [CFG_DATA_W-1:0] rm);
        write_reg(rsplt_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(rsplt_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(rsplt_pkg::CFG_OVERLAP, CFG_DATA_W'(ov));
        write_reg(rsplt_pkg::CFG_REMOSAIC, rm);
        phase_count++;
    endtask

    // Pause until every predicted write has come out
    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_axis_tvalid || tile_writes_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_random_pixels(int n);
        repeat (n) pixel_q.push_back(S_DATA_W'($urandom));
    endtask

    initial begin
        int unsigned w, h, ov, half, sel;
        int random_pixels;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = rsplt_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data      = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        pixel_taken     = 1'b0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        mismatch_count  = 0;
        pixels_sent     = 0;
        writes_checked  = 0;
        split_pixels    = 0;
        phase_count     = 0;
        random_pixels   = 0;
        geo_width       = rsplt_pkg::RST_IMAGE_WIDTH;
        geo_height      = rsplt_pkg::RST_IMAGE_HEIGHT;
        geo_overlap     = rsplt_pkg::RST_OVERLAP;
        geo_remosaic    = rsplt_pkg::RST_REMOSAIC;
        col_count       = '0;
        row_count       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry, byte extremes
        pixel_q.push_back(16'h0000);
        pixel_q.push_back(16'hFFFF);
        pixel_q.push_back(16'h000F);
        pixel_q.push_back(16'hFFF0);
        wait_drained();

        // Width and height below range, no overlap
        set_geometry(0, 0, 0, 1);
        pixel_q.push_back(16'h5AA5);
        pixel_q.push_back(16'hA55A);
        pixel_q.push_back(16'h0F0F);
        pixel_q.push_back(16'hF0F0);
        wait_drained();

        // Width not a multiple of four, overlap far past half: swaps leave the frame
        set_geometry(6, 2, 14'h3FFF, 14'h3FFF);
        queue_random_pixels(12);
        wait_drained();

        // Width above range, overlap at half; remosaic off
        set_geometry(16383, 16383, 4096, 14'h2AAA);
        queue_random_pixels(3);
        wait_drained();

        // Random phases, cycling through the idle patterns
        while (random_pixels < 900) begin
            sel = $urandom_range(19);
            if (sel == 0)      w = $urandom_range(0, 3);
            else if (sel == 1) w = $urandom_range(8192, 16383);
            else if (sel < 5)  w = $urandom_range(4, 48);
            else               w = $urandom_range(1, 12) * 4;
            sel = $urandom_range(19);
            if (sel == 0)      h = 0;
            else if (sel == 1) h = $urandom_range(8192, 16383);
            else               h = $urandom_range(1, 10);
            half = clamp_width(w) >> 1;
            sel = $urandom_range(9);
            if (sel == 0)      ov = $urandom_range(0, 16383);
            else if (sel == 1) ov = 0;
            else if (sel == 2) ov = half;
            else               ov = $urandom_range(0, half + 2);
            set_geometry(w, h, ov, CFG_DATA_W'($urandom));
            case (phase_count % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 59; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 59; end
                default: begin sender_idle_pct = 27; sink_stall_pct = 27; end
            endcase
            sel = $urandom_range(20, 40);
            queue_random_pixels(sel);
            random_pixels += sel;
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("Covered %0d pixels in %0d geometry phases: %0d tile writes checked,",
                 pixels_sent, phase_count, writes_checked);
        $display("%0d pixels split into both tiles.", split_pixels);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rsplt_pkg.sv
hw/rtl/rsplt_coord.sv
hw/rtl/raw_split_tiler_with_remosaic_unit.sv
dv/testbench.sv
